/* src/pm_pkg.sv */
package pm_pkg;

  // Operand store span: term_power addresses at most this many entries
  localparam int unsigned POW_W      = 4;
  localparam int unsigned ADDR_SPAN  = 1 << POW_W;
  localparam int unsigned TERMS_DEF  = 16;
  localparam int unsigned COEFF_W    = 32;
  localparam int unsigned RPOW_W     = 5;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned PROD_W     = 2 * COEFF_W;
  localparam int unsigned FRAC_W     = 16;
  localparam logic [COEFF_W-1:0] ROUND_BIAS = 32'h0000_8000;

  // Command selector of an input word
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_A = 2'd0,
    FUNC_WR_B = 2'd1,
    FUNC_MUL  = 2'd2,
    FUNC_CLR  = 2'd3
  } func_e;

  // Microprogram step addresses
  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_KINIT = 3'd1,
    STEP_MAC   = 3'd2,
    STEP_DRAIN = 3'd3,
    STEP_WAIT  = 3'd4,
    STEP_EMIT  = 3'd5
  } step_e;

  // Branch conditions tested by the sequencer
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_MUL_GO = 2'd1,
    COND_I_LAST = 2'd2,
    COND_K_LAST = 2'd3
  } cond_e;

  // One control word of the microprogram
  typedef struct packed {
    logic  in_rdy;    // take a command word
    logic  acc_init;  // load rounding bias, set pair index to first pair
    logic  mac;       // multiply pair, accumulate previous product
    logic  drain;     // accumulate the final product
    logic  out_wait;  // hold until the result register is free
    logic  emit;      // load result register, advance power
    cond_e cond;
    step_e next_t;
    step_e next_f;
  } ctrl_t;

  // Microprogram ROM
  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    w = '{in_rdy: 1'b0, acc_init: 1'b0, mac: 1'b0, drain: 1'b0, out_wait: 1'b0,
          emit: 1'b0, cond: COND_ALWAYS, next_t: STEP_IDLE, next_f: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_MUL_GO;
        w.next_t = STEP_KINIT;
        w.next_f = STEP_IDLE;
      end
      STEP_KINIT: begin
        w.acc_init = 1'b1;
        w.next_t   = STEP_MAC;
        w.next_f   = STEP_MAC;
      end
      STEP_MAC: begin
        w.mac    = 1'b1;
        w.cond   = COND_I_LAST;
        w.next_t = STEP_DRAIN;
        w.next_f = STEP_MAC;
      end
      STEP_DRAIN: begin
        w.drain  = 1'b1;
        w.next_t = STEP_WAIT;
        w.next_f = STEP_WAIT;
      end
      STEP_WAIT: begin
        // branch target chosen by result register state in the sequencer
        w.out_wait = 1'b1;
        w.next_t   = STEP_EMIT;
        w.next_f   = STEP_WAIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_K_LAST;
        w.next_t = STEP_IDLE;
        w.next_f = STEP_KINIT;
      end
      default: begin
        w.next_t = STEP_IDLE;
        w.next_f = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* src/pm_cmd_if.sv */
interface pm_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [pm_pkg::FUNC_W-1:0]          func;
  logic [pm_pkg::POW_W-1:0]           term_power;
  logic signed [pm_pkg::COEFF_W-1:0]  term_coeff;

  modport source (output valid, output func, output term_power, output term_coeff,
                  input ready);
  modport sink   (input valid, input func, input term_power, input term_coeff,
                  output ready);
endinterface

/* src/pm_res_if.sv */
interface pm_res_if;
  logic                               valid;
  logic                               ready;
  logic [pm_pkg::RPOW_W-1:0]          result_power;
  logic signed [pm_pkg::COEFF_W-1:0]  result_coeff;
  logic                               saturated;
  logic                               last;

  modport source (output valid, output result_power, output result_coeff,
                  output saturated, output last, input ready);
  modport sink   (input valid, input result_power, input result_coeff,
                  input saturated, input last, output ready);
endinterface

/* src/polynomial_multiply_top.sv */
// Polynomial multiplier over two coefficient stores of E = min(TERMS, 16) signed Q16.16
// entries. A write or clear command word is taken in the idle step and leaves the block
// idle. A multiply word makes the block emit 2*E-1 result words, power 0 up to 2*E-2, the
// last one flagged; each is the exact sum of its Q32.32 pair products, rounded half up to
// Q16.16 and saturated. One multiply-accumulate unit, stepped by a microprogram, handles
// one coefficient pair per cycle; each result power runs the steps KINIT, MAC for each
// pair, DRAIN, WAIT and EMIT, and WAIT holds while the result register is full and not
// taken. No command word is taken while a multiply runs.
module polynomial_multiply_top #(
  parameter int unsigned TERMS = pm_pkg::TERMS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pm_cmd_if.sink        cmd_i,
  pm_res_if.source      res_o
);

  localparam int unsigned E     = (TERMS < pm_pkg::ADDR_SPAN) ? TERMS : pm_pkg::ADDR_SPAN;
  localparam int unsigned IW    = $clog2(E);
  localparam int unsigned KW    = $clog2(2 * E - 1);
  localparam int unsigned ACC_W = pm_pkg::PROD_W + IW + 2;
  localparam int unsigned SAT_LO = pm_pkg::COEFF_W - 1 + pm_pkg::FRAC_W;
  localparam logic [KW-1:0] EM1   = KW'(E - 1);
  localparam logic [KW-1:0] KLAST = KW'(2 * E - 2);

  // Sequencer state
  pm_pkg::step_e step_q, step_d;
  pm_pkg::ctrl_t cw;
  logic          cond_ok;

  // Datapath registers
  logic signed [pm_pkg::COEFF_W-1:0] a_q [E];
  logic signed [pm_pkg::COEFF_W-1:0] b_q [E];
  logic [KW-1:0]                     k_q;
  logic [IW-1:0]                     i_q;
  logic                              prodv_q;
  logic signed [pm_pkg::PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]           acc_q;

  // Result register
  logic                              ovalid_q;
  logic [pm_pkg::RPOW_W-1:0]         opow_q;
  logic signed [pm_pkg::COEFF_W-1:0] ocoeff_q;
  logic                              osat_q;
  logic                              olast_q;

  logic              cmd_acc;
  pm_pkg::func_e     func;
  logic              wr_ok;
  logic [IW-1:0]     wr_idx;
  logic [KW-1:0]     ilo_w;
  logic [KW-1:0]     ihi_w;
  logic [KW-1:0]     j_w;
  logic [IW-1:0]     j_idx;
  logic signed [pm_pkg::PROD_W-1:0] prod_d;
  logic              res_free;
  logic              k_last;
  logic              hi_ones;
  logic              hi_zeros;
  logic              sat_w;
  logic [pm_pkg::COEFF_W-1:0] coeff_w;

  // Command decode
  assign cw       = pm_pkg::ucode(step_q);
  assign cmd_i.ready = cw.in_rdy;
  assign cmd_acc  = cmd_i.valid && cw.in_rdy;
  assign func     = pm_pkg::func_e'(cmd_i.func);
  assign wr_ok    = ({1'b0, cmd_i.term_power} < (pm_pkg::POW_W + 1)'(E));
  assign wr_idx   = cmd_i.term_power[IW-1:0];

  // Pair index range for the current power
  assign ilo_w  = (k_q >= EM1) ? (k_q - EM1) : '0;
  assign ihi_w  = (k_q < EM1) ? k_q : EM1;
  assign j_w    = k_q - KW'(i_q);
  assign j_idx  = j_w[IW-1:0];
  assign prod_d = a_q[i_q] * b_q[j_idx];
  assign k_last = (k_q == KLAST);
  assign res_free = !ovalid_q || res_o.ready;

  // Branch condition select
  always_comb begin
    unique case (cw.cond)
      pm_pkg::COND_ALWAYS: cond_ok = 1'b1;
      pm_pkg::COND_MUL_GO: cond_ok = cmd_acc && (func == pm_pkg::FUNC_MUL);
      pm_pkg::COND_I_LAST: cond_ok = (KW'(i_q) == ihi_w);
      pm_pkg::COND_K_LAST: cond_ok = k_last;
      default:             cond_ok = 1'b0;
    endcase
    if (cw.out_wait) begin
      cond_ok = res_free;
    end
    step_d = cond_ok ? cw.next_t : cw.next_f;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pm_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Operand stores: writes and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < E; n++) begin
        a_q[n] <= '0;
        b_q[n] <= '0;
      end
    end else if (cmd_acc) begin
      unique case (func)
        pm_pkg::FUNC_WR_A: if (wr_ok) a_q[wr_idx] <= cmd_i.term_coeff;
        pm_pkg::FUNC_WR_B: if (wr_ok) b_q[wr_idx] <= cmd_i.term_coeff;
        pm_pkg::FUNC_CLR: begin
          for (int n = 0; n < E; n++) begin
            a_q[n] <= '0;
            b_q[n] <= '0;
          end
        end
        pm_pkg::FUNC_MUL: ;
        default: ;
      endcase
    end
  end

  // Power counter, pair index and multiply-accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      i_q     <= '0;
      prodv_q <= 1'b0;
    end else begin
      if (cmd_acc) begin
        k_q <= '0;
      end else if (cw.emit) begin
        k_q <= k_q + KW'(1);
      end
      if (cw.acc_init) begin
        i_q     <= ilo_w[IW-1:0];
        prodv_q <= 1'b0;
      end else if (cw.mac) begin
        i_q     <= i_q + IW'(1);
        prodv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.mac) begin
      prod_q <= prod_d;
    end
    if (cw.acc_init) begin
      acc_q <= ACC_W'(pm_pkg::ROUND_BIAS);
    end else if ((cw.mac && prodv_q) || cw.drain) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Round and saturate
  assign hi_ones  = &acc_q[ACC_W-1:SAT_LO];
  assign hi_zeros = ~|acc_q[ACC_W-1:SAT_LO];
  assign sat_w    = !(hi_ones || hi_zeros);
  assign coeff_w  = sat_w ? (acc_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                          : acc_q[SAT_LO:pm_pkg::FRAC_W];

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cw.emit) begin
      ovalid_q <= 1'b1;
    end else if (res_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.emit) begin
      opow_q   <= pm_pkg::RPOW_W'(k_q);
      ocoeff_q <= coeff_w;
      osat_q   <= sat_w;
      olast_q  <= k_last;
    end
  end

  assign res_o.valid        = ovalid_q;
  assign res_o.result_power = opow_q;
  assign res_o.result_coeff = ocoeff_q;
  assign res_o.saturated    = osat_q;
  assign res_o.last         = olast_q;

  // Checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == pm_pkg::STEP_EMIT) |-> !ovalid_q)
    else $error("result register overwritten");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == pm_pkg::STEP_MAC) |-> (KW'(i_q) <= ihi_w) && (KW'(i_q) >= ilo_w))
    else $error("pair index out of range");

  a_last_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> (opow_q == pm_pkg::RPOW_W'(2 * E - 2)))
    else $error("last flag on wrong power");

  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (func == pm_pkg::FUNC_MUL)) |=> (step_q == pm_pkg::STEP_KINIT) && (k_q == '0))
    else $error("multiply did not start at power zero");

endmodule
